// ===== src/chs3_pkg.sv =====
// shared types and constants for the three-way cuckoo hash set
`default_nettype none
package chs3_pkg;
	localparam int unsigned KEY_W = 28;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic CFG_TABLE_SIZE = 1'b0;
	localparam logic CFG_MAX_KICKS  = 1'b1;

	localparam logic [15:0] LFSR_MASK  = 16'hB400;
	localparam logic [15:0] LFSR_RESET = 16'h0001;

	typedef struct packed {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic             success;
		logic             overflow;
		logic [KEY_W-1:0] homeless_key;
	} rsp_t;
endpackage
`default_nettype wire

// ===== src/chs3_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module chs3_ram #(
	parameter int unsigned WIDTH = 28,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== src/cuckoo_hash_set_three_way_unit.sv =====
// top level of the three-way cuckoo hash set
// overflow after max_kicks displacement rounds; op 3 or an insert with zero max_kicks answers straight from idle
// three modulo reductions per key, each a restoring divider of KEY_W+3 steps
// throughput: one request at a time; stall low only in idle
// reset: a clearing pass over all TABLE_DEPTH slots empties them; lfsr 1, sizes 1024 and 32
`default_nettype none
module cuckoo_hash_set_three_way_unit #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire chs3_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output chs3_pkg::rsp_t     out_data,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [10:0]   cfg_data
);
	localparam int unsigned AW  = $clog2(TABLE_DEPTH);
	localparam int unsigned SW  = AW + 1;
	localparam int unsigned KW  = chs3_pkg::KEY_W;
	localparam int unsigned PW  = KW + 3;
	localparam int unsigned DCW = $clog2(PW + 1);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_DIV, ST_RD, ST_RDW, ST_CHK, ST_KICK,
		ST_KRD, ST_KRDW, ST_KWR, ST_OUT
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic [10:0]      tsize_q;
	logic [7:0]       kicks_q;
	logic [15:0]      lfsr_q;
	logic [1:0]       op_q;
	logic [KW-1:0]    key_q;
	logic [7:0]       round_q;
	logic [1:0]       hidx_q;
	logic [AW-1:0]    cand_q [3];
	logic [SW-1:0]    size_q;
	logic [PW-1:0]    num_q;
	logic [SW:0]      rem_q;
	logic [DCW-1:0]   dcnt_q;
	logic [AW-1:0]    vslot_q;
	chs3_pkg::rsp_t   rsp_q;

	// shared address and write ports
	logic             k_we, u_we, u_wdata;
	logic [AW-1:0]    addr;
	logic [KW-1:0]    k_wdata, k_rdata;
	logic [0:0]       u_rdata;
	logic [15:0]      lfsr_nx;
	logic [4:0]       m3_a;
	logic [2:0]       m3_b, m3_c;
	logic [1:0]       pick;
	logic [SW:0]      rem_sh;
	logic [PW-1:0]    mul_key;

	chs3_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_key (
		.clk(clk), .we(k_we), .addr(addr), .wdata(k_wdata), .rdata(k_rdata)
	);
	chs3_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_used (
		.clk(clk), .we(u_we), .addr(addr), .wdata(u_wdata), .rdata(u_rdata)
	);

	always_comb begin
		lfsr_nx = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? chs3_pkg::LFSR_MASK : 16'd0);
		// mod 3 by folding base-4 digits
		m3_a = 5'(lfsr_nx[1:0]) + 5'(lfsr_nx[3:2]) + 5'(lfsr_nx[5:4]) + 5'(lfsr_nx[7:6])
			+ 5'(lfsr_nx[9:8]) + 5'(lfsr_nx[11:10]) + 5'(lfsr_nx[13:12])
			+ 5'(lfsr_nx[15:14]);
		m3_b = 3'(m3_a[1:0]) + 3'(m3_a[3:2]) + 3'(m3_a[4]);
		m3_c = 3'(m3_b[1:0]) + 3'(m3_b[2]);
		pick = (m3_c >= 3'd3) ? 2'(m3_c - 3'd3) : m3_c[1:0];
		rem_sh = {rem_q[SW-1:0], num_q[PW-1]};
		case (hidx_q)
			2'd0:    mul_key = PW'(key_q);
			2'd1:    mul_key = PW'(key_q) + (PW'(key_q) << 1);
			default: mul_key = (PW'(key_q) << 2) + (PW'(key_q) << 1) + PW'(key_q);
		endcase
		addr = cand_q[hidx_q];
		k_we = 1'b0;
		u_we = 1'b0;
		u_wdata = 1'b0;
		k_wdata = key_q;
		case (state_q)
			ST_CLEAR: begin
				addr = clr_q;
				u_we = 1'b1;
			end
			ST_CHK: begin
				if (op_q == chs3_pkg::OP_INSERT && !u_rdata[0]) begin
					k_we = 1'b1;
					u_we = 1'b1;
					u_wdata = 1'b1;
				end else if (op_q == chs3_pkg::OP_REMOVE && u_rdata[0] && k_rdata == key_q) begin
					u_we = 1'b1;
				end
			end
			ST_KRD, ST_KRDW: addr = vslot_q;
			ST_KWR: begin
				addr = vslot_q;
				k_we = 1'b1;
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			tsize_q <= 11'd1024;
			kicks_q <= 8'd32;
			lfsr_q  <= chs3_pkg::LFSR_RESET;
			op_q    <= '0;
			key_q   <= '0;
			round_q <= '0;
			hidx_q  <= '0;
			size_q  <= '0;
			num_q   <= '0;
			rem_q   <= '0;
			dcnt_q  <= '0;
			vslot_q <= '0;
			rsp_q   <= '0;
			for (int i = 0; i < 3; i++) cand_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == chs3_pkg::CFG_TABLE_SIZE) tsize_q <= cfg_data;
				else kicks_q <= cfg_data[7:0];
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= in_data.op;
						key_q   <= in_data.key;
						round_q <= '0;
						if (tsize_q == 11'd0) size_q <= SW'(1);
						else if (32'(tsize_q) > TABLE_DEPTH) size_q <= SW'(TABLE_DEPTH);
						else size_q <= SW'(tsize_q);
						if (in_data.op == chs3_pkg::OP_NONE) begin
							rsp_q   <= '0;
							state_q <= ST_OUT;
						end else if (in_data.op == chs3_pkg::OP_INSERT && kicks_q == 8'd0) begin
							rsp_q   <= '{1'b0, 1'b1, in_data.key};
							state_q <= ST_OUT;
						end else begin
							rsp_q   <= '0;
							hidx_q  <= '0;
							state_q <= ST_HASH;
						end
					end
				end
				ST_HASH: begin
					num_q   <= mul_key;
					rem_q   <= '0;
					dcnt_q  <= DCW'(PW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					num_q <= {num_q[PW-2:0], 1'b0};
					if (rem_sh >= {1'b0, size_q}) rem_q <= rem_sh - {1'b0, size_q};
					else rem_q <= rem_sh;
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DCW'(1)) begin
						if (hidx_q == 2'd2) begin
							hidx_q  <= '0;
							state_q <= ST_RD;
						end else begin
							hidx_q  <= hidx_q + 1'b1;
							state_q <= ST_HASH;
						end
					end
				end
				ST_RD: state_q <= ST_RDW;
				ST_RDW: state_q <= ST_CHK;
				ST_CHK: begin
					if (op_q == chs3_pkg::OP_INSERT) begin
						if (!u_rdata[0]) begin
							rsp_q.success <= 1'b1;
							state_q <= ST_OUT;
						end else if (hidx_q == 2'd2) state_q <= ST_KICK;
						else begin
							hidx_q  <= hidx_q + 1'b1;
							state_q <= ST_RDW;
						end
					end else begin
						if (u_rdata[0] && k_rdata == key_q) begin
							rsp_q.success <= 1'b1;
							state_q <= ST_OUT;
						end else if (hidx_q == 2'd2) state_q <= ST_OUT;
						else begin
							hidx_q  <= hidx_q + 1'b1;
							state_q <= ST_RDW;
						end
					end
				end
				ST_KICK: begin
					lfsr_q  <= lfsr_nx;
					vslot_q <= cand_q[pick];
					state_q <= ST_KRD;
				end
				ST_KRD: state_q <= ST_KRDW;
				ST_KRDW: state_q <= ST_KWR;
				ST_KWR: begin
					key_q   <= k_rdata;
					round_q <= round_q + 1'b1;
					if (round_q + 8'd1 == kicks_q) begin
						rsp_q   <= '{1'b0, 1'b1, k_rdata};
						state_q <= ST_OUT;
					end else begin
						hidx_q  <= '0;
						state_q <= ST_HASH;
					end
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			// capture remainder when a divide finishes
			if (state_q == ST_DIV && dcnt_q == DCW'(1)) begin
				if (rem_sh >= {1'b0, size_q}) cand_q[hidx_q] <= AW'(rem_sh - {1'b0, size_q});
				else cand_q[hidx_q] <= AW'(rem_sh);
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/chs3_checker.sv =====
// port-level checks for the cuckoo hash set
`default_nettype none
module chs3_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_stall,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire chs3_pkg::rsp_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.success && out_data.overflow))
		else $error("success and overflow together");
	a_homeless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.overflow |-> out_data.homeless_key == '0)
		else $error("homeless key without overflow");
endmodule

bind cuckoo_hash_set_three_way_unit chs3_checker u_chs3_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench for the three-way cuckoo hash set unit
`timescale 1ns / 100ps
`default_nettype none

class cuckoo_set_tracker;
	logic [chs3_pkg::KEY_W-1:0] slot_key[1024];
	bit slot_used[1024];
	logic [15:0] evict_lfsr;
	int unsigned table_size;
	int unsigned max_kicks;
	chs3_pkg::rsp_t pending_rsp[$];
	int unsigned mismatches;
	int unsigned inserts, searches, removes, hits, overflows;

	function new();
		foreach (slot_used[i]) slot_used[i] = 0;
		evict_lfsr = chs3_pkg::LFSR_RESET;
		table_size = 1024;
		max_kicks = 32;
	endfunction

	function int unsigned size_in_use();
		if (table_size == 0) return 1;
		if (table_size > 1024) return 1024;
		return table_size;
	endfunction

	function void note_request(chs3_pkg::req_t req);
		chs3_pkg::rsp_t rsp;
		int unsigned s, v, slot[3];
		logic [chs3_pkg::KEY_W-1:0] carried, evicted;
		longint unsigned k;
		bit placed;
		rsp = '0;
		s = size_in_use();
		carried = req.key;
		placed = 0;
		case (chs3_pkg::op_t'(req.op))
			chs3_pkg::OP_INSERT: begin
				inserts++;
				for (int r = 0; r < max_kicks && !placed; r++) begin
					k = carried;
					slot[0] = k % s;
					slot[1] = (k * 3) % s;
					slot[2] = (k * 7) % s;
					for (int i = 0; i < 3 && !placed; i++) begin
						if (!slot_used[slot[i]]) begin
							slot_used[slot[i]] = 1;
							slot_key[slot[i]] = carried;
							placed = 1;
						end
					end
					if (!placed) begin
						evict_lfsr = evict_lfsr[0] ? ((evict_lfsr >> 1) ^ chs3_pkg::LFSR_MASK)
							: (evict_lfsr >> 1);
						v = slot[evict_lfsr % 3];
						evicted = slot_key[v];
						slot_key[v] = carried;
						carried = evicted;
					end
				end
				if (placed) begin
					rsp.success = 1;
				end else begin
					rsp.overflow = 1;
					rsp.homeless_key = carried;
					overflows++;
				end
			end
			chs3_pkg::OP_SEARCH, chs3_pkg::OP_REMOVE: begin
				if (chs3_pkg::op_t'(req.op) == chs3_pkg::OP_SEARCH) searches++;
				else removes++;
				k = req.key;
				slot[0] = k % s;
				slot[1] = (k * 3) % s;
				slot[2] = (k * 7) % s;
				for (int i = 0; i < 3 && !placed; i++) begin
					if (slot_used[slot[i]] && slot_key[slot[i]] == req.key) begin
						if (chs3_pkg::op_t'(req.op) == chs3_pkg::OP_REMOVE) slot_used[slot[i]] = 0;
						rsp.success = 1;
						placed = 1;
						hits++;
					end
				end
			end
			default: begin
			end
		endcase
		pending_rsp = {pending_rsp, rsp};
	endfunction

	function void check_response(chs3_pkg::rsp_t got);
		chs3_pkg::rsp_t want;
		if (pending_rsp.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected response %p", got);
			return;
		end
		want = pending_rsp.pop_front();
		if (got.success !== want.success || got.overflow !== want.overflow
				|| got.homeless_key !== want.homeless_key) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected success %0d overflow %0d key %h, got %0d %0d %h",
					want.success, want.overflow, want.homeless_key,
					got.success, got.overflow, got.homeless_key);
		end
	endfunction
endclass

module testbench;
	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	chs3_pkg::req_t in_data;
	chs3_pkg::rsp_t out_data;
	logic cfg_we, cfg_index;
	logic [10:0] cfg_data;

	cuckoo_set_tracker tracker;
	logic [chs3_pkg::KEY_W-1:0] known_keys[$];
	bit hold_req;
	int unsigned hold_left, seg_left, seg_kind;

	cuckoo_hash_set_three_way_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#50_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_request(chs3_pkg::op_t op, logic [chs3_pkg::KEY_W-1:0] key);
		int unsigned gap;
		@(negedge clk);
		in_valid = 1'b1;
		in_data.op = op;
		in_data.key = key;
		do @(posedge clk); while (in_stall);
		tracker.note_request(in_data);
		if (op == chs3_pkg::OP_INSERT) known_keys = {known_keys, key};
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.pending_rsp.size() != 0) @(negedge clk);
	endtask

	task automatic write_config(logic index, int unsigned value);
		wait_drained();
		repeat (150) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = 11'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		if (index == chs3_pkg::CFG_TABLE_SIZE) tracker.table_size = value & 11'h7FF;
		else tracker.max_kicks = value & 8'hFF;
	endtask

	function automatic logic [chs3_pkg::KEY_W-1:0] fresh_key();
		if ($urandom_range(0, 1)) return chs3_pkg::KEY_W'($urandom());
		return chs3_pkg::KEY_W'($urandom_range(0, 4095));
	endfunction

	function automatic logic [chs3_pkg::KEY_W-1:0] some_key();
		if (known_keys.size() != 0 && $urandom_range(0, 99) < 70)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		return fresh_key();
	endfunction

	task automatic random_requests(int unsigned count);
		int unsigned r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 40) send_request(chs3_pkg::OP_INSERT, fresh_key());
			else if (r < 65) send_request(chs3_pkg::OP_SEARCH, some_key());
			else if (r < 95) send_request(chs3_pkg::OP_REMOVE, some_key());
			else send_request(chs3_pkg::OP_NONE, chs3_pkg::KEY_W'($urandom()));
		end
	endtask

	task automatic run_phase(int unsigned size, int unsigned kicks, int unsigned count);
		write_config(chs3_pkg::CFG_TABLE_SIZE, size);
		write_config(chs3_pkg::CFG_MAX_KICKS, kicks);
		random_requests(count);
	endtask

	// receiver: free stretches, choppy stalls, long stalls, and requested hold-offs
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		seg_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				if (seg_left == 0) begin
					seg_kind = $urandom_range(0, 9);
					seg_left = (seg_kind < 9) ? $urandom_range(20, 200) : $urandom_range(10, 60);
				end
				seg_left--;
				if (seg_kind < 4) out_stall = 1'b0;
				else if (seg_kind < 9) out_stall = ($urandom_range(0, 2) == 0);
				else out_stall = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) tracker.check_response(out_data);
	end

	initial begin
		tracker = new();
		hold_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = chs3_pkg::CFG_TABLE_SIZE;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		send_request(chs3_pkg::OP_SEARCH, '0);
		send_request(chs3_pkg::OP_INSERT, '0);
		send_request(chs3_pkg::OP_INSERT, 28'h0FFF_FFFF);
		send_request(chs3_pkg::OP_SEARCH, '0);
		send_request(chs3_pkg::OP_SEARCH, 28'h0FFF_FFFF);
		send_request(chs3_pkg::OP_INSERT, 28'd1024);
		send_request(chs3_pkg::OP_INSERT, '0);
		send_request(chs3_pkg::OP_SEARCH, 28'd1024);
		send_request(chs3_pkg::OP_REMOVE, '0);
		send_request(chs3_pkg::OP_REMOVE, '0);
		send_request(chs3_pkg::OP_REMOVE, 28'h0FFF_FFFF);
		send_request(chs3_pkg::OP_REMOVE, 28'h0AAA_AAAA);
		send_request(chs3_pkg::OP_SEARCH, 28'h0555_5555);
		send_request(chs3_pkg::OP_NONE, 28'h0FFF_FFFF);
		send_request(chs3_pkg::OP_INSERT, 28'h0555_5555);
		send_request(chs3_pkg::OP_INSERT, 28'h0AAA_AAAA);
		send_request(chs3_pkg::OP_SEARCH, 28'h0AAA_AAAA);
		send_request(chs3_pkg::OP_NONE, '0);

		run_phase(1024, 255, 400);
		run_phase(37, 8, 300);
		run_phase(1, 1, 100);
		run_phase(4, 255, 15);
		run_phase(0, 3, 100);
		run_phase(2047, 0, 150);

		write_config(chs3_pkg::CFG_TABLE_SIZE, 513);
		write_config(chs3_pkg::CFG_MAX_KICKS, 16);
		hold_req = 1'b1;
		random_requests(200);
		wait_drained();
		random_requests(200);

		run_phase(1024, 32, 435);

		wait_drained();
		repeat (300) @(negedge clk);
		$display("covered %0d inserts, %0d searches, %0d removes over eight table settings",
			tracker.inserts, tracker.searches, tracker.removes);
		$display("lookups hit %0d times, inserts overflowed %0d times, %0d mismatches",
			tracker.hits, tracker.overflows, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== files.f =====
src/chs3_pkg.sv
src/chs3_ram.sv
src/cuckoo_hash_set_three_way_unit.sv
src/chs3_checker.sv
bench/testbench.sv
